>>> hdl/athc_pkg.sv
`timescale 1ns / 1ps

package athc_pkg;

  // operating modes, also the code on the result channel
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_IDLE = 2'd1;
  localparam logic [1:0] MODE_HEAT = 2'd2;
  localparam logic [1:0] MODE_COOL = 2'd3;

  localparam int RAW_W    = 8;
  localparam int SET_W    = 8;
  localparam int MARGIN_W = 8;
  localparam int DEG_W    = 7;
  localparam int SUM_W    = 12;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd5;

  // degrees = floor(raw * 488 / 1000) = floor(raw * 65498384 / 2^27), exact for 8-bit raw
  localparam int SCALE_MUL_W = 26;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 26'd65498384;
  localparam int SCALE_PROD_W = RAW_W + SCALE_MUL_W;

  typedef struct packed {
    logic             button_level;
    logic [DEG_W-1:0] degrees;
    logic [SET_W-1:0] setpoint;
  } sample_t;

  function automatic logic [DEG_W-1:0] scale_degrees(input logic [RAW_W-1:0] raw);
    logic [SCALE_PROD_W-1:0] prod;
    prod = SCALE_PROD_W'(raw) * SCALE_PROD_W'(SCALE_MUL);
    return prod[SCALE_PROD_W-1 -: DEG_W];
  endfunction

endpackage

>>> hdl/athc_in_stage.sv
`timescale 1ns / 1ps

module athc_in_stage
  import athc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] button_level, [8:1] raw_sample, [16:9] setpoint, [23:17] zero
  input  logic [23:0] in_tdata,
  input  logic        take,
  output logic        item_valid,
  output sample_t     item
);

  logic    valid_r;
  sample_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // sample is converted to degrees on the way in
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.button_level <= in_tdata[0];
      item_r.degrees      <= scale_degrees(in_tdata[8:1]);
      item_r.setpoint     <= in_tdata[16:9];
    end
  end

endmodule

>>> hdl/athc_core.sv
`timescale 1ns / 1ps

module athc_core
  import athc_pkg::*;
#(
  parameter int READINGS_PER_DECISION = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [MARGIN_W-1:0] cfg_wr_data,
  input  logic                step,
  input  sample_t             item,
  output logic [1:0]          mode_nxt
);

  localparam int CNT_W = $clog2(READINGS_PER_DECISION + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(READINGS_PER_DECISION);
  // avg = floor(sum * RECIP / 2^RECIP_SHIFT), exact for any 12-bit sum
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + READINGS_PER_DECISION - 1) / READINGS_PER_DECISION);
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int CMP_W  = SUM_W + 1;

  logic [1:0]          mode_r;
  logic                press_r;
  logic [CNT_W-1:0]    count_r;
  logic [SUM_W-1:0]    sum_r;
  logic [MARGIN_W-1:0] margin_r;

  logic                press_nxt;
  logic [CNT_W-1:0]    count_nxt;
  logic [SUM_W-1:0]    sum_nxt;

  logic                press;
  logic [1:0]          mode_mid;
  logic                active;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]    sum_inc;
  logic [PROD_W-1:0]   avg_prod;
  logic [CMP_W-1:0]    avg;
  logic [CMP_W-1:0]    set_ext;
  logic [CMP_W-1:0]    margin_ext;
  logic                want_heat;
  logic                want_cool;
  logic [1:0]          decided;

  always_comb begin
    press    = !item.button_level && !press_r;
    mode_mid = mode_r;
    if (press) begin
      mode_mid = (mode_r != MODE_OFF) ? MODE_OFF : MODE_IDLE;
    end
    // latch follows the level: set on press, held while low, cleared on release
    press_nxt = !item.button_level;
    active    = (mode_mid != MODE_OFF);

    cnt_inc    = count_r + CNT_W'(1);
    sum_inc    = sum_r + SUM_W'(item.degrees);
    avg_prod   = PROD_W'(sum_inc) * PROD_W'(RECIP);
    avg        = CMP_W'(avg_prod[PROD_W-1:RECIP_SHIFT]);
    set_ext    = CMP_W'(item.setpoint);
    margin_ext = CMP_W'(margin_r);
    want_heat  = set_ext > (avg + margin_ext);
    want_cool  = avg > (set_ext + margin_ext);

    if (want_heat) begin
      decided = MODE_HEAT;
    end else if (want_cool) begin
      decided = MODE_COOL;
    end else if (mode_mid == MODE_IDLE) begin
      decided = (avg > set_ext) ? MODE_COOL : MODE_HEAT;
    end else begin
      decided = mode_mid;
    end

    mode_nxt  = mode_mid;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (active) begin
      if (cnt_inc == CNT_LAST) begin
        mode_nxt  = decided;
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = cnt_inc;
        sum_nxt   = sum_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      press_r  <= 1'b0;
      count_r  <= '0;
      sum_r    <= '0;
      margin_r <= MARGIN_RESET;
    end else begin
      if (step) begin
        mode_r  <= mode_nxt;
        press_r <= press_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
      if (cfg_wr_en) begin
        margin_r <= cfg_wr_data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_LAST)
    else $error("reading count passed the decision point");

  a_off_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode_r == MODE_OFF && item.button_level)
    |=> (mode_r == MODE_OFF && $stable(count_r) && $stable(sum_r)))
    else $error("count or sum moved while off");

  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    (step && active && cnt_inc == CNT_LAST)
    |=> (count_r == '0 && sum_r == '0 && (mode_r == MODE_HEAT || mode_r == MODE_COOL)))
    else $error("decision did not clear the window or pick heat/cool");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.button_level) |=> !press_r)
    else $error("press latch held after release");
`endif

endmodule

>>> hdl/averaged_thermostat_heat_cool.sv
`timescale 1ns / 1ps

// Averaged heat/cool thermostat with a hysteresis band.
// Input channel (in_*): one item per tick, carrying the active-low on/off
// button level, the raw 8-bit temperature sample and the set temperature.
// Result channel (out_*): exactly one item per input item, the mode after
// that tick (0 off, 1 on idle, 2 heating, 3 cooling).
// Config port: cfg_wr_en/cfg_wr_data load the 8-bit band margin; write it
// only while no item is in flight.
// The sample is scaled to degrees on its way into the input register; once
// the output register is free or draining, the mode logic loads it and
// out_tvalid rises. Throughput is one item per cycle while out_tready stays
// high; the mode state loop closes through the state registers around the
// accumulate/average/compare logic.
// Every READINGS_PER_DECISION samples taken while on, the average is formed
// and a new heat/cool mode chosen.
// Reset: mode on idle, margin 5, window count and sum zero, no press latched.
// When out_tready is low the output register holds its item; the input
// register still takes one more item, then in_tready drops until the output
// drains.
module averaged_thermostat_heat_cool
  import athc_pkg::*;
#(
  parameter int READINGS_PER_DECISION = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] button_level, [8:1] raw_sample, [16:9] setpoint, [23:17] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] mode, [7:2] zero
  output logic [7:0]  out_tdata
);

  logic       item_valid;
  sample_t    item;
  logic       take;
  logic [1:0] mode_nxt;
  logic       out_valid_r;
  logic [1:0] out_mode_r;

  assign take = item_valid && (!out_valid_r || out_tready);

  athc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  athc_core #(
    .READINGS_PER_DECISION (READINGS_PER_DECISION)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (take),
    .item        (item),
    .mode_nxt    (mode_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_mode_r <= mode_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_mode_r};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import athc_pkg::*;

  localparam int READINGS   = 10;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 230;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  averaged_thermostat_heat_cool #(
    .READINGS_PER_DECISION(READINGS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // shadow thermostat state
  logic [1:0]          th_mode;
  logic                th_latched;
  logic [3:0]          th_count;
  logic [SUM_W-1:0]    th_sum;
  logic [MARGIN_W-1:0] th_margin;

  logic [1:0] mode_q[$];
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int results_seen;
  int mismatches;
  int mode_hist[4];
  int base_raw;
  int base_set;

  typedef struct packed {
    logic       btn;
    logic [7:0] raw;
    logic [7:0] setp;
    logic       wr_margin;
    logic [7:0] margin_val;
    logic       typed;
    logic [1:0] mode;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b1, MODE_IDLE},
    '{1'b0, 8'd0,   8'd0,   1'b0, 8'd0,   1'b1, MODE_OFF},   // press turns off
    '{1'b0, 8'd255, 8'd255, 1'b0, 8'd0,   1'b1, MODE_OFF},   // held press, no toggle
    '{1'b1, 8'd255, 8'd255, 1'b0, 8'd0,   1'b1, MODE_OFF},
    '{1'b0, 8'd255, 8'd0,   1'b0, 8'd0,   1'b1, MODE_IDLE},  // press while off, sample taken
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd255, 8'd0,   1'b0, 8'd0,   1'b1, MODE_COOL},  // hottest window
    '{1'b1, 8'd0,   8'd255, 1'b1, 8'd255, 1'b0, MODE_OFF},   // widest band
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd0,   8'd255, 1'b0, 8'd0,   1'b1, MODE_COOL},  // band too wide, mode kept
    '{1'b1, 8'd128, 8'd62,  1'b1, 8'd0,   1'b0, MODE_OFF},
    '{1'b1, 8'd1,   8'd254, 1'b0, 8'd0,   1'b0, MODE_OFF}
  };

  function automatic logic [1:0] advance_thermostat(input logic btn, input logic [7:0] raw,
                                                    input logic [7:0] setp);
    int deg;
    int avg;
    if (!btn && !th_latched) begin
      th_latched = 1'b1;
      th_mode = (th_mode != MODE_OFF) ? MODE_OFF : MODE_IDLE;
    end
    if (btn) th_latched = 1'b0;
    if (th_mode != MODE_OFF) begin
      deg = (int'(raw) * 488) / 1000;
      th_count = th_count + 4'd1;
      th_sum = th_sum + deg[SUM_W-1:0];
      if (int'(th_count) == READINGS) begin
        avg = int'(th_sum) / READINGS;
        if (int'(setp) > avg + int'(th_margin)) th_mode = MODE_HEAT;
        if (avg > int'(setp) + int'(th_margin)) th_mode = MODE_COOL;
        if (th_mode != MODE_HEAT && th_mode != MODE_COOL)
          th_mode = (avg > int'(setp)) ? MODE_COOL : MODE_HEAT;
        th_count = '0;
        th_sum = '0;
      end
    end
    return th_mode;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d items sent, %0d results seen", items_sent, results_seen);
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    logic [1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      mode_hist[out_tdata[1:0]]++;
      if (mode_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item on result channel: mode %0d", out_tdata[1:0]);
      end else begin
        want = mode_q.pop_front();
        if (out_tdata[1:0] !== want || out_tdata[7:2] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: mode expected %0d, got %0d (tdata 0x%02h)",
                     results_seen, want, out_tdata[1:0], out_tdata);
        end
      end
    end
  end

  // called at a falling edge where in_tvalid has not yet been assigned
  task automatic send_reading(input logic btn, input logic [7:0] raw, input logic [7:0] setp,
                              input logic typed, input logic [1:0] typed_mode);
    logic [1:0] m;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, setp, raw, btn};
    do @(posedge clk); while (!in_tready);
    m = advance_thermostat(btn, raw, setp);
    mode_q.push_back(typed ? typed_mode : m);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every item has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (mode_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_margin(input logic [7:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    th_margin = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_reading();
    int raw;
    int setp;
    logic btn;
    if ($urandom_range(0, 39) == 0) begin
      base_raw = $urandom_range(0, 255);
      base_set = (base_raw * 488) / 1000 + $urandom_range(0, 2 * int'(th_margin) + 8)
                 - int'(th_margin) - 4;
    end
    btn = ($urandom_range(0, 24) != 0) || (!th_latched && $urandom_range(0, 1) == 0);
    if ($urandom_range(0, 9) == 0) begin
      raw = $urandom_range(0, 255);
      setp = $urandom_range(0, 255);
    end else begin
      raw = base_raw + $urandom_range(0, 8) - 4;
      setp = base_set + $urandom_range(0, 4) - 2;
    end
    if (raw < 0) raw = 0;
    if (raw > 255) raw = 255;
    if (setp < 0) setp = 0;
    if (setp > 255) setp = 255;
    send_reading(btn, raw[7:0], setp[7:0], 1'b0, MODE_OFF);
  endtask

  initial begin
    static int send_pct [NUM_PHASES] = '{0, 68, 0, 20, 0, 68, 0, 20};
    static int recv_pct [NUM_PHASES] = '{0, 0, 68, 20, 0, 0, 68, 20};
    static int margins  [NUM_PHASES] = '{5, 0, 255, 12, -1, 2, 128, 1};
    logic [7:0] mval;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    base_raw = 100;
    base_set = 48;
    th_mode = MODE_IDLE;
    th_latched = 1'b0;
    th_count = '0;
    th_sum = '0;
    th_margin = MARGIN_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_margin) write_margin(dir_rows[i].margin_val);
      send_reading(dir_rows[i].btn, dir_rows[i].raw, dir_rows[i].setp,
                   dir_rows[i].typed, dir_rows[i].mode);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      mval = (margins[p] < 0) ? 8'($urandom_range(0, 255)) : 8'(margins[p]);
      write_margin(mval);
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once so the pipeline runs dry mid-phase
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_random_reading();
      end
    end

    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    for (int w = 0; w < 20000 && mode_q.size() != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mode_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", mode_q.size());
    end

    $display("ran %0d thermostat ticks over %0d margin settings, %0d results checked",
             items_sent, NUM_PHASES + 3, results_seen);
    $display("modes seen: off %0d, idle %0d, heat %0d, cool %0d; %0d mismatches",
             mode_hist[0], mode_hist[1], mode_hist[2], mode_hist[3], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/athc_pkg.sv
hdl/athc_in_stage.sv
hdl/athc_core.sv
hdl/averaged_thermostat_heat_cool.sv
tb/tb_top.sv
